// ----- sv/cevb_pkg.sv -----
// ----------------------------------------------------------------------------
// cevb_pkg
// shared types, codes and helpers of the event io refresh bridge
// ----------------------------------------------------------------------------
package cevb_pkg;

  localparam int TBL_DEPTH = 16;
  localparam int SLOT_W    = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // command codes of the input word
  localparam logic [2:0] CMD_RX    = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_SETLV = 3'd2;
  localparam logic [2:0] CMD_LDIN  = 3'd3;
  localparam logic [2:0] CMD_LDOUT = 3'd4;
  localparam logic [2:0] CMD_START = 3'd5;

  // bus opcodes
  localparam logic [7:0] OPC_ON   = 8'h90;
  localparam logic [7:0] OPC_OFF  = 8'h91;
  localparam logic [7:0] OPC_REQ  = 8'h92;
  localparam logic [7:0] OPC_RON  = 8'h93;
  localparam logic [7:0] OPC_ROFF = 8'h94;

  // register indexes
  localparam logic [2:0] REG_BASE_ID   = 3'd0;
  localparam logic [2:0] REG_MAJOR     = 3'd1;
  localparam logic [2:0] REG_MINOR     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_PRELOAD   = 3'd4;

  localparam logic [6:0]  RST_BASE_ID = 7'h7F;
  localparam logic [1:0]  RST_MAJOR   = 2'd1;
  localparam logic [1:0]  RST_MINOR   = 2'd1;
  localparam logic [15:0] RST_TIMEOUT = 16'd30000;
  localparam logic [11:0] RST_PRELOAD = 12'd500;

  localparam int DEF_INPUT_SLOTS  = 16;
  localparam int DEF_OUTPUT_SLOTS = 16;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_RX_ON,
    OP_RX_OFF,
    OP_TICK,
    OP_SETLV,
    OP_LDIN,
    OP_LDOUT,
    OP_START
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [15:0]       node;
    logic [15:0]       event_req;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       levels;
  } q_item_t;

  typedef struct packed {
    logic [6:0]  base_id;
    logic [1:0]  major_priority;
    logic [1:0]  minor_priority;
    logic [15:0] refresh_timeout;
    logic [11:0] preload_step;
  } cfg_t;

  // saturating age increment
  function automatic logic [15:0] bump(input logic [15:0] a);
    bump = (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

endpackage

// ----- sv/cevb_if.sv -----
// ----------------------------------------------------------------------------
// cevb_in_if / cevb_out_if
// valid-ready channels for command words and result words
// ----------------------------------------------------------------------------
interface cevb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  opcode;
  logic [15:0] node;
  logic [15:0] event_req;
  logic [3:0]  slot;
  logic [15:0] levels;

  modport source (output valid, cmd, opcode, node, event_req, slot, levels, input ready);
  modport sink   (input valid, cmd, opcode, node, event_req, slot, levels, output ready);
endinterface

interface cevb_out_if;
  logic        valid;
  logic        ready;
  logic        is_frame;
  logic [10:0] frame_id;
  logic [7:0]  frame_opcode;
  logic [15:0] frame_node;
  logic [15:0] frame_event;
  logic [15:0] input_image;
  logic        last;

  modport source (output valid, is_frame, frame_id, frame_opcode, frame_node, frame_event,
                  input_image, last, input ready);
  modport sink   (input valid, is_frame, frame_id, frame_opcode, frame_node, frame_event,
                  input_image, last, output ready);
endinterface

// ----- sv/cevb_front.sv -----
// ----------------------------------------------------------------------------
// cevb_front
// accepts command words and classifies them for the back end
// ----------------------------------------------------------------------------
module cevb_front
  import cevb_pkg::*;
#(
  parameter int INPUT_SLOTS  = DEF_INPUT_SLOTS,
  parameter int OUTPUT_SLOTS = DEF_OUTPUT_SLOTS
) (
  cevb_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_item
);

  logic in_slot_ok;
  logic out_slot_ok;

  assign in_slot_ok  = {1'b0, in_ch.slot} < 5'(INPUT_SLOTS);
  assign out_slot_ok = {1'b0, in_ch.slot} < 5'(OUTPUT_SLOTS);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.node      = in_ch.node;
    q_item.event_req = in_ch.event_req;
    q_item.slot      = in_ch.slot;
    q_item.levels    = in_ch.levels;
    case (in_ch.cmd)
      CMD_RX: begin
        if (in_ch.opcode == OPC_ON || in_ch.opcode == OPC_RON) q_item.op = OP_RX_ON;
        else if (in_ch.opcode == OPC_OFF || in_ch.opcode == OPC_ROFF) q_item.op = OP_RX_OFF;
        else q_item.op = OP_NOP;
      end
      CMD_TICK:  q_item.op = OP_TICK;
      CMD_SETLV: q_item.op = OP_SETLV;
      CMD_LDIN:  q_item.op = in_slot_ok ? OP_LDIN : OP_NOP;
      CMD_LDOUT: q_item.op = out_slot_ok ? OP_LDOUT : OP_NOP;
      CMD_START: q_item.op = OP_START;
      default:   q_item.op = OP_NOP;
    endcase
  end

endmodule

// ----- sv/cevb_queue.sv -----
// ----------------------------------------------------------------------------
// cevb_queue
// two-entry queue of classified commands between front and back
// ----------------------------------------------------------------------------
module cevb_queue
  import cevb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output q_item_t q_data
);

  q_item_t    mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

// ----- sv/cevb_back.sv -----
// ----------------------------------------------------------------------------
// cevb_back
// event tables and the sequencer that scans them and emits result words
// ----------------------------------------------------------------------------
module cevb_back
  import cevb_pkg::*;
#(
  parameter int INPUT_SLOTS  = DEF_INPUT_SLOTS,
  parameter int OUTPUT_SLOTS = DEF_OUTPUT_SLOTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  q_item_t  q_data,
  output logic     q_pop,
  cevb_out_if.source out_ch
);

  localparam int SCAN_SLOTS = (INPUT_SLOTS > OUTPUT_SLOTS) ? INPUT_SLOTS : OUTPUT_SLOTS;
  localparam logic [SLOT_W-1:0] OUT_LAST  = SLOT_W'(OUTPUT_SLOTS - 1);
  localparam logic [SLOT_W-1:0] IN_LAST   = SLOT_W'(INPUT_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SCAN_SLOTS - 1);
  localparam logic [TBL_DEPTH-1:0] IN_MASK  = TBL_DEPTH'((33'd1 << INPUT_SLOTS) - 33'd1);
  localparam logic [TBL_DEPTH-1:0] OUT_MASK = TBL_DEPTH'((33'd1 << OUTPUT_SLOTS) - 33'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN_OUT,
    S_RUN_IN,
    S_START,
    S_STATUS
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic              running_r, running_nxt;

  logic [15:0] in_node_r  [TBL_DEPTH];
  logic [15:0] in_event_r [TBL_DEPTH];
  logic [15:0] in_age_r   [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] in_level_r;
  logic [15:0] out_node_r  [TBL_DEPTH];
  logic [15:0] out_event_r [TBL_DEPTH];
  logic [15:0] out_age_r   [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] out_wanted_r;
  logic [TBL_DEPTH-1:0] out_sent_r;

  // output register
  logic        ov_r, ov_nxt;
  logic        o_isf_r, o_isf_nxt;
  logic [7:0]  o_op_r, o_op_nxt;
  logic [15:0] o_node_r, o_node_nxt;
  logic [15:0] o_ev_r, o_ev_nxt;
  logic [15:0] o_img_r, o_img_nxt;
  logic        o_last_r, o_last_nxt;

  logic        ospace;
  logic [15:0] img;
  logic [15:0] on_node, in_node_sel;
  logic [15:0] o_age_b, i_age_b;
  logic        o_fire, i_fire;
  logic        in_idx_ok, out_idx_ok;
  logic [10:0] frame_id;

  assign ospace      = !ov_r || out_ch.ready;
  assign img         = in_level_r & IN_MASK;
  assign on_node     = out_node_r[idx_r];
  assign in_node_sel = in_node_r[idx_r];
  assign o_age_b     = bump(out_age_r[idx_r]);
  assign i_age_b     = bump(in_age_r[idx_r]);
  assign o_fire      = (on_node != 16'd0) &&
                       (o_age_b >= cfg.refresh_timeout ||
                        out_sent_r[idx_r] != out_wanted_r[idx_r]);
  assign i_fire      = (in_node_sel != 16'd0) && (i_age_b >= cfg.refresh_timeout);
  assign in_idx_ok   = {1'b0, idx_r} < 5'(INPUT_SLOTS);
  assign out_idx_ok  = {1'b0, idx_r} < 5'(OUTPUT_SLOTS);
  assign frame_id    = 11'(cfg.base_id) + {cfg.major_priority, 9'd0} +
                       {2'd0, cfg.minor_priority, 7'd0};

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    running_nxt = running_r;
    q_pop       = 1'b0;
    ov_nxt      = ov_r && !out_ch.ready;
    o_isf_nxt   = o_isf_r;
    o_op_nxt    = o_op_r;
    o_node_nxt  = o_node_r;
    o_ev_nxt    = o_ev_r;
    o_img_nxt   = o_img_r;
    o_last_nxt  = o_last_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          idx_nxt = '0;
          case (q_data.op)
            OP_TICK:  state_nxt = running_r ? S_RUN_OUT : S_STATUS;
            OP_START: begin
              running_nxt = 1'b1;
              acc_nxt     = 16'd0;
              state_nxt   = S_START;
            end
            default:  state_nxt = S_STATUS;
          endcase
        end
      end
      S_RUN_OUT: begin
        if (ospace) begin
          if (o_fire) begin
            ov_nxt     = 1'b1;
            o_isf_nxt  = 1'b1;
            o_op_nxt   = out_wanted_r[idx_r] ? OPC_ON : OPC_OFF;
            o_node_nxt = on_node;
            o_ev_nxt   = out_event_r[idx_r];
            o_img_nxt  = img;
            o_last_nxt = 1'b0;
          end
          if (idx_r == OUT_LAST) begin
            idx_nxt   = '0;
            state_nxt = S_RUN_IN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_RUN_IN: begin
        if (ospace) begin
          if (i_fire) begin
            ov_nxt     = 1'b1;
            o_isf_nxt  = 1'b1;
            o_op_nxt   = OPC_REQ;
            o_node_nxt = in_node_sel;
            o_ev_nxt   = in_event_r[idx_r];
            o_img_nxt  = img;
            o_last_nxt = 1'b0;
          end
          if (idx_r == IN_LAST) state_nxt = S_STATUS;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_START: begin
        if (ospace) begin
          if (in_idx_ok && in_node_sel != 16'd0) begin
            ov_nxt     = 1'b1;
            o_isf_nxt  = 1'b1;
            o_op_nxt   = OPC_REQ;
            o_node_nxt = in_node_sel;
            o_ev_nxt   = in_event_r[idx_r];
            o_img_nxt  = img;
            o_last_nxt = 1'b0;
          end
          acc_nxt = acc_r + 16'(cfg.preload_step);
          if (idx_r == SCAN_LAST) state_nxt = S_STATUS;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_STATUS: begin
        if (ospace) begin
          ov_nxt     = 1'b1;
          o_isf_nxt  = 1'b0;
          o_op_nxt   = 8'd0;
          o_node_nxt = 16'd0;
          o_ev_nxt   = 16'd0;
          o_img_nxt  = img;
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      acc_r        <= 16'd0;
      running_r    <= 1'b0;
      ov_r         <= 1'b0;
      in_level_r   <= '0;
      out_wanted_r <= '0;
      out_sent_r   <= '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        in_node_r[i]   <= 16'd0;
        in_event_r[i]  <= 16'd0;
        in_age_r[i]    <= 16'd0;
        out_node_r[i]  <= 16'd0;
        out_event_r[i] <= 16'd0;
        out_age_r[i]   <= 16'd0;
      end
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      acc_r     <= acc_nxt;
      running_r <= running_nxt;
      ov_r      <= ov_nxt;
      if (state_r == S_IDLE && q_valid) begin
        case (q_data.op)
          OP_RX_ON, OP_RX_OFF: begin
            if (running_r) begin
              for (int i = 0; i < INPUT_SLOTS; i++) begin
                if (in_node_r[i] != 16'd0 && in_node_r[i] == q_data.node &&
                    in_event_r[i] == q_data.event_req) begin
                  in_level_r[i] <= (q_data.op == OP_RX_ON);
                  in_age_r[i]   <= 16'd0;
                end
              end
            end
          end
          OP_SETLV: out_wanted_r <= q_data.levels & OUT_MASK;
          OP_LDIN: begin
            in_node_r[q_data.slot]  <= q_data.node;
            in_event_r[q_data.slot] <= q_data.event_req;
          end
          OP_LDOUT: begin
            out_node_r[q_data.slot]  <= q_data.node;
            out_event_r[q_data.slot] <= q_data.event_req;
          end
          default: ;
        endcase
      end
      if (ospace) begin
        case (state_r)
          S_RUN_OUT: begin
            if (on_node != 16'd0) begin
              out_age_r[idx_r] <= o_fire ? 16'd0 : o_age_b;
              if (o_fire) out_sent_r[idx_r] <= out_wanted_r[idx_r];
            end
          end
          S_RUN_IN: begin
            if (in_node_sel != 16'd0) in_age_r[idx_r] <= i_fire ? 16'd0 : i_age_b;
          end
          S_START: begin
            if (out_idx_ok) out_age_r[idx_r] <= acc_r;
            if (in_idx_ok && in_node_sel != 16'd0) in_age_r[idx_r] <= acc_r;
          end
          default: ;
        endcase
      end
    end
    o_isf_r  <= o_isf_nxt;
    o_op_r   <= o_op_nxt;
    o_node_r <= o_node_nxt;
    o_ev_r   <= o_ev_nxt;
    o_img_r  <= o_img_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.is_frame     = o_isf_r;
  assign out_ch.frame_id     = o_isf_r ? frame_id : 11'd0;
  assign out_ch.frame_opcode = o_op_r;
  assign out_ch.frame_node   = o_node_r;
  assign out_ch.frame_event  = o_ev_r;
  assign out_ch.input_image  = o_img_r;
  assign out_ch.last         = o_last_r;

  a_status_not_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_last_r |-> !o_isf_r)
    else $error("closing word flagged as frame");

  a_frame_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_isf_r |-> running_r)
    else $error("frame emitted before start");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STATUS && ospace |=> state_r == S_IDLE && ov_r && o_last_r)
    else $error("status word not issued at end of command");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && q_valid)
    else $error("unexpected pop");

endmodule

// ----- sv/can_event_io_refresh_bridge.sv -----
// ----------------------------------------------------------------------------
// can_event_io_refresh_bridge
// event io refresh bridge: input/output event tables with aged refresh
//
//   port group  role    content
//   in_ch       sink    command word: cmd, opcode, node, event_req, slot, levels
//   out_ch      source  result word: frame fields, input_image, last
//   p*          apb     configuration registers at byte address 4*index
//
// a command word is classified combinationally and written into a two-entry
// queue; the back end takes one command at a time, pops it, scans the entries
// it needs and ends with a status word. loads, level writes, received frames
// and ticks before start go straight to the status word; a tick after start
// scans the output then the input slots; start scans the larger slot range.
// with the back end idle a command word passes the queue, the state register
// and the output register before its first result word is valid. a stalled
// out_ch holds the scan; the queue keeps accepting until full. reset (rst_n,
// synchronous) clears both tables, stops the block, loads register defaults
// ----------------------------------------------------------------------------
module can_event_io_refresh_bridge
  import cevb_pkg::*;
#(
  parameter int INPUT_SLOTS  = DEF_INPUT_SLOTS,
  parameter int OUTPUT_SLOTS = DEF_OUTPUT_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  cevb_in_if.sink           in_ch,
  cevb_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg_r;
  logic    cfg_wr;
  logic    [2:0] reg_idx;

  logic    q_push;
  q_item_t q_item;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_data;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id         <= RST_BASE_ID;
      cfg_r.major_priority  <= RST_MAJOR;
      cfg_r.minor_priority  <= RST_MINOR;
      cfg_r.refresh_timeout <= RST_TIMEOUT;
      cfg_r.preload_step    <= RST_PRELOAD;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASE_ID: cfg_r.base_id         <= pwdata[6:0];
        REG_MAJOR:   cfg_r.major_priority  <= pwdata[1:0];
        REG_MINOR:   cfg_r.minor_priority  <= pwdata[1:0];
        REG_TIMEOUT: cfg_r.refresh_timeout <= pwdata[15:0];
        REG_PRELOAD: cfg_r.preload_step    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_idx)
      REG_BASE_ID: prdata = DATA_W'(cfg_r.base_id);
      REG_MAJOR:   prdata = DATA_W'(cfg_r.major_priority);
      REG_MINOR:   prdata = DATA_W'(cfg_r.minor_priority);
      REG_TIMEOUT: prdata = DATA_W'(cfg_r.refresh_timeout);
      REG_PRELOAD: prdata = DATA_W'(cfg_r.preload_step);
      default:     prdata = '0;
    endcase
  end

  // front: accept and classify
  cevb_front #(
    .INPUT_SLOTS  (INPUT_SLOTS),
    .OUTPUT_SLOTS (OUTPUT_SLOTS)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  // decoupling queue
  cevb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // back: tables, scans, result words
  cevb_back #(
    .INPUT_SLOTS  (INPUT_SLOTS),
    .OUTPUT_SLOTS (OUTPUT_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
